@@ sv/ntc_table_interpolator_top_macros.svh @@
// assertion macros shared by the thermistor interpolator modules
// expects aclk and aresetn in the scope of each use
`ifndef NTC_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define NTC_TABLE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define NTCI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ntci assertion failed");

// next-cycle implication, off during reset
`define NTCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ntci assertion failed");

`endif

@@ sv/ntci_pkg.sv @@
// types, codes and constants of the thermistor table interpolator
// no dependencies
`timescale 1ns / 1ps

package ntci_pkg;

    // table size and field widths
    localparam int NTCI_TABLE_DEPTH = 128;
    localparam int RES_W            = 24;
    localparam int IDX_W            = 7;
    localparam int TEMP_W           = 17;
    localparam int Q_BITS           = 8;
    localparam int CFG_DATA_W       = 8;
    localparam int CFG_IDX_W        = 1;

    // saturation limits of the q8 result
    localparam int Q8_MAX = 65535;
    localparam int Q8_MIN = -65536;

    // register reset values
    localparam logic [7:0]        ENTRIES_USED_RST = 8'd111;
    localparam logic signed [6:0] BASE_TEMP_RST    = -7'sd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TEMP    = 1'd1;

    // input commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // clamp codes
    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_COLD = 2'd1;
    localparam logic [1:0] CLAMP_HOT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_COLD,
        ST_CHK_HOT,
        ST_SCAN,
        ST_DIV_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_NEXT
    } addr_sel_t;

    typedef struct packed {
        logic      load_wr;   // write table entry from the input beat
        logic      start;     // capture resistance, clear scan index
        logic      rd_en;     // table read
        addr_sel_t addr_sel;
        logic      k_step;    // advance scan index
        logic      take_hi;   // keep read entry as upper bound
        logic      set_cold;
        logic      set_hot;
        logic      set_hit;
        logic      div_prep;
        logic      div_step;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cold;      // r at or above entry zero
        logic hot;       // r at or below last entry
        logic hit;       // interval brackets r
        logic scan_end;  // scan index at last entry
        logic div_last;  // final quotient bit
        logic out_free;  // output register can take a beat
    } dp_status_t;

endpackage

@@ sv/ntc_table_interpolator_top.sv @@
// top level of the thermistor table interpolator
// depends on ntci_pkg, ntci_ctrl and ntci_datapath
`timescale 1ns / 1ps

// Converts a measured thermistor resistance to a signed q8 temperature by
// piecewise-linear interpolation in a table of resistances at one-degree
// steps, entry k at base_temp + k degrees, falling as temperature rises.
// A beat with s_cmd low writes entry s_entry_index (indexes at or beyond
// TABLE_DEPTH are dropped) and gives no result.
// A beat with s_cmd high converts s_resistance_ohms: values at or above entry
// zero clamp cold (status 1), values at or below the last used entry clamp
// hot (status 2), otherwise the first bracketing interval found scanning up
// from entry zero is interpolated with round half up (status 0).
// A conversion holds the input through the cold check, the hot check and,
// if not clamped, a scan over up to n entries, n being entries_used held
// to the range 2 to TABLE_DEPTH: one table read per cycle through the single
// memory read port drives the scan, followed by a restoring divider for the
// fraction (rounding can carry it to a whole degree). The result sits
// in an output register, so the next beat is taken while a result still
// waits on m_ready; only a new result meeting a full output register waits
// until m_ready frees it.
// Entries must be written before a conversion reads them. Configuration (index
// 0 entries_used, index 1 base_temp) must be written only while idle (not enforced).

module ntc_table_interpolator_top
    import ntci_pkg::*;
#(
    parameter int TABLE_DEPTH = NTCI_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    // input beats
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic [RES_W-1:0]         s_resistance_ohms,
    // result beats
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temperature_q8,
    output logic [1:0]               m_clamp_status
);

    // command and status between controller and datapath
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequences the cold check, hot check, scan, divide and result hand-off
    ntci_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // holds the table, configuration, divider and output register
    ntci_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_entry_index     (s_entry_index),
        .s_resistance_ohms (s_resistance_ohms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temperature_q8  (m_temperature_q8),
        .m_clamp_status    (m_clamp_status),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

@@ sv/ntci_ctrl.sv @@
// controller state machine of the thermistor table interpolator
// depends on ntci_pkg and ntc_table_interpolator_top_macros.svh
`timescale 1ns / 1ps
`include "ntc_table_interpolator_top_macros.svh"

module ntci_ctrl
    import ntci_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_cmd,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_cmd == CMD_CONVERT) begin
                    state_next = ST_CHK_COLD;
                end
            end
            ST_CHK_COLD: begin
                state_next = sts.cold ? ST_OUT : ST_CHK_HOT;
            end
            ST_CHK_HOT: begin
                state_next = sts.hot ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.hit) begin
                    state_next = ST_DIV_PREP;
                end else if (sts.scan_end) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_PREP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.addr_sel = ADDR_ZERO;
        s_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == CMD_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else begin
                        cmd.start    = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.addr_sel = ADDR_ZERO;
                    end
                end
            end
            ST_CHK_COLD: begin
                cmd.take_hi = 1'b1;
                if (sts.cold) begin
                    cmd.set_cold = 1'b1;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_LAST;
                end
            end
            ST_CHK_HOT: begin
                if (sts.hot) begin
                    cmd.set_hot = 1'b1;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_NEXT;
                    cmd.k_step   = 1'b1;
                end
            end
            ST_SCAN: begin
                if (sts.hit) begin
                    cmd.set_hit = 1'b1;
                end else if (sts.scan_end) begin
                    cmd.set_hot = 1'b1;
                end else begin
                    cmd.take_hi  = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_NEXT;
                    cmd.k_step   = 1'b1;
                end
            end
            ST_DIV_PREP: begin
                cmd.div_prep = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `NTCI_ASSERT_IMPL(a_out_load_free, cmd.out_load, sts.out_free)
    `NTCI_ASSERT_NEXT(a_div_to_out, state_reg == ST_DIV && sts.div_last, state_reg == ST_OUT)
    `NTCI_ASSERT_NEXT(a_scan_holds, state_reg == ST_SCAN && !sts.hit && !sts.scan_end, state_reg == ST_SCAN && $past(cmd.k_step))

endmodule

@@ sv/ntci_datapath.sv @@
// table memory, search registers, serial divider and output register
// depends on ntci_pkg
`timescale 1ns / 1ps

module ntci_datapath
    import ntci_pkg::*;
#(
    parameter int TABLE_DEPTH = NTCI_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic [RES_W-1:0]         s_resistance_ohms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temperature_q8,
    output logic [1:0]               m_clamp_status,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               sts
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int EW   = (CW > 8) ? CW : 8;
    localparam int LW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int IT_W = ((IW + 1 > 7) ? IW + 1 : 7) + 1;
    localparam int TW   = IT_W + Q_BITS;
    localparam int SW   = (TW > TEMP_W) ? TW : TEMP_W;
    localparam int QCW  = $clog2(Q_BITS + 1);

    localparam logic signed [SW-1:0] SAT_MAX = SW'(Q8_MAX);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(Q8_MIN);
    localparam logic [EW-1:0] DEPTH_E = EW'(TABLE_DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_MAX = IW'(TABLE_DEPTH - 1);

    // configuration
    logic [7:0]        entries_used_reg;
    logic signed [6:0] base_temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_used_reg <= ENTRIES_USED_RST;
            base_temp_reg    <= BASE_TEMP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENTRIES_USED: entries_used_reg <= cfg_wdata;
                REG_BASE_TEMP:    base_temp_reg    <= $signed(cfg_wdata[6:0]);
                default:          entries_used_reg <= entries_used_reg;
            endcase
        end
    end

    // index of the last used entry
    logic [EW-1:0] eu_ext;
    logic [IW-1:0] last_idx;

    always_comb begin
        eu_ext = EW'(entries_used_reg);
        if (eu_ext < EW'(2)) begin
            last_idx = IW'(1);
        end else if (eu_ext > DEPTH_E) begin
            last_idx = LAST_MAX;
        end else begin
            last_idx = IW'(eu_ext - EW'(1));
        end
    end

    // table memory
    logic [RES_W-1:0] mem [TABLE_DEPTH];
    logic [RES_W-1:0] rdata_reg;
    logic [IW-1:0]    rd_addr;
    logic             load_ok;

    assign load_ok = LW'(s_entry_index) < DEPTH_L;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_ok) begin
            mem[IW'(s_entry_index)] <= s_resistance_ohms;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // search registers
    logic [RES_W-1:0] r_reg;
    logic [RES_W-1:0] hi_reg;
    logic [IW-1:0]    k_reg;

    always_comb begin
        case (cmd.addr_sel)
            ADDR_ZERO: rd_addr = '0;
            ADDR_LAST: rd_addr = last_idx;
            ADDR_NEXT: rd_addr = IW'(k_reg + 1'b1);
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            r_reg <= s_resistance_ohms;
            k_reg <= '0;
        end else if (cmd.k_step) begin
            k_reg <= IW'(k_reg + 1'b1);
        end
        if (cmd.take_hi) begin
            hi_reg <= rdata_reg;
        end
    end

    // result fields and serial divider
    logic [1:0]        status_reg;
    logic [IW-1:0]     tidx_reg;
    logic [Q_BITS:0]   q_reg;
    logic [RES_W-1:0]  d_reg;
    logic [RES_W-1:0]  diff_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [Q_BITS:0]   nlow_reg;
    logic [QCW-1:0]    cnt_reg;
    logic [RES_W:0]    partial;
    logic [RES_W:0]    num_top;
    logic              qbit;

    // numerator is diff*256 + d/2; its part above bit 7 is below 2*d, so the
    // quotient needs 9 bits and can reach a whole degree when rounding carries
    assign num_top = {1'b0, diff_reg} + {1'b0, d_reg >> (Q_BITS + 1)};
    assign partial = {rem_reg, nlow_reg[Q_BITS]};
    assign qbit    = partial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (cmd.set_cold) begin
            status_reg <= CLAMP_COLD;
            tidx_reg   <= '0;
            q_reg      <= '0;
        end else if (cmd.set_hot) begin
            status_reg <= CLAMP_HOT;
            tidx_reg   <= last_idx;
            q_reg      <= '0;
        end else if (cmd.set_hit) begin
            status_reg <= CLAMP_NONE;
            tidx_reg   <= IW'(k_reg - 1'b1);
            d_reg      <= hi_reg - rdata_reg;
            diff_reg   <= hi_reg - r_reg;
        end else if (cmd.div_prep) begin
            // top part of the numerator over 512 is below d
            rem_reg  <= num_top[RES_W:1];
            nlow_reg <= {num_top[0], d_reg[Q_BITS:1]};
            q_reg    <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= qbit ? RES_W'(partial - {1'b0, d_reg}) : partial[RES_W-1:0];
            nlow_reg <= {nlow_reg[Q_BITS-1:0], 1'b0};
            q_reg    <= {q_reg[Q_BITS-1:0], qbit};
            cnt_reg  <= QCW'(cnt_reg + 1'b1);
        end
    end

    // temperature assembly and saturation
    logic signed [IT_W-1:0] base_ext;
    logic signed [IT_W-1:0] int_sum;
    logic signed [TW-1:0]   temp_wide;
    logic signed [SW-1:0]   temp_ext;
    logic signed [TEMP_W-1:0] temp_sat;

    always_comb begin
        base_ext  = IT_W'(base_temp_reg);
        int_sum   = base_ext + $signed(IT_W'(tidx_reg));
        temp_wide = $signed({int_sum, {Q_BITS{1'b0}}}) + $signed(TW'(q_reg));
        temp_ext  = SW'(temp_wide);
        if (temp_ext > SAT_MAX) begin
            temp_sat = TEMP_W'(SAT_MAX);
        end else if (temp_ext < SAT_MIN) begin
            temp_sat = TEMP_W'(SAT_MIN);
        end else begin
            temp_sat = TEMP_W'(temp_ext);
        end
    end

    // output register
    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] m_temp_reg;
    logic [1:0]               m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_temp_reg   <= temp_sat;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_temperature_q8 = m_temp_reg;
    assign m_clamp_status   = m_status_reg;

    assign sts.cold     = r_reg >= rdata_reg;
    assign sts.hot      = r_reg <= rdata_reg;
    assign sts.hit      = (r_reg <= hi_reg) && (r_reg > rdata_reg);
    assign sts.scan_end = k_reg == last_idx;
    assign sts.div_last = cnt_reg == QCW'(Q_BITS);
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

@@ sim/ntci_conversion_checker.sv @@
// result checker for the thermistor table interpolator testbench
// depends on ntci_pkg; snoops the config port and both beat channels
`timescale 1ns / 1ps

module ntci_conversion_checker
    import ntci_pkg::*;
#(
    parameter int TABLE_DEPTH = NTCI_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [IDX_W-1:0]         s_entry_index,
    input  logic [RES_W-1:0]         s_resistance_ohms,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [TEMP_W-1:0] m_temperature_q8,
    input  logic [1:0]               m_clamp_status,
    output int                       outstanding,
    output int                       mismatches
);

    localparam longint Q_ONE = longint'(1) << Q_BITS;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [1:0]               status;
    } thermo_result_t;

    logic [RES_W-1:0]  ohms_table [TABLE_DEPTH];
    logic [7:0]        entries_reg;
    logic signed [6:0] base_reg;
    thermo_result_t    temps_due [$];

    initial begin
        outstanding = 0;
        mismatches  = 0;
    end

    // cold or hot clamp at the ends, else first falling interval from entry zero, fraction rounded half up
    function automatic thermo_result_t interpolate_temperature(input logic [RES_W-1:0] r);
        thermo_result_t res;
        longint n, base, t, hi, lo, rr, d, num, i;
        logic found;
        n = longint'(entries_reg);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        base = longint'(base_reg);
        rr = longint'(r);
        t = (base + n - 1) * Q_ONE;
        res.status = CLAMP_HOT;
        found = 1'b0;
        if (rr >= longint'(ohms_table[0])) begin
            t = base * Q_ONE;
            res.status = CLAMP_COLD;
        end else if (rr > longint'(ohms_table[n-1])) begin
            for (i = 0; i + 1 < n && !found; i++) begin
                hi = longint'(ohms_table[i]);
                lo = longint'(ohms_table[i+1]);
                if (rr <= hi && rr > lo) begin
                    d = hi - lo;
                    num = (hi - rr) * Q_ONE + d / 2;
                    t = (base + i) * Q_ONE + num / d;
                    res.status = CLAMP_NONE;
                    found = 1'b1;
                end
            end
        end
        if (t > Q8_MAX) t = Q8_MAX;
        if (t < Q8_MIN) t = Q8_MIN;
        res.temp = t[TEMP_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        thermo_result_t want;
        if (!aresetn) begin
            entries_reg = ENTRIES_USED_RST;
            base_reg    = BASE_TEMP_RST;
            temps_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (temps_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got temp %0d status %0d",
                             $time, m_temperature_q8, m_clamp_status);
                end else begin
                    want = temps_due.pop_front();
                    if (m_temperature_q8 !== want.temp) begin
                        mismatches++;
                        $display("%0t: temperature_q8 expected %0d got %0d",
                                 $time, $signed(want.temp), m_temperature_q8);
                    end
                    if (m_clamp_status !== want.status) begin
                        mismatches++;
                        $display("%0t: clamp_status expected %0d got %0d",
                                 $time, want.status, m_clamp_status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_CONVERT)
                    temps_due.push_back(interpolate_temperature(s_resistance_ohms));
                else if (s_entry_index < TABLE_DEPTH)
                    ohms_table[s_entry_index] = s_resistance_ohms;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENTRIES_USED: entries_reg = cfg_wdata;
                    REG_BASE_TEMP:    base_reg = cfg_wdata[6:0];
                    default: ;
                endcase
            end
        end
        outstanding = temps_due.size();
    end

endmodule

@@ sim/tb_ntc_table_interpolator_top.sv @@
// testbench top for the thermistor table interpolator: clock, reset, stimulus, verdict
// depends on ntci_pkg, ntc_table_interpolator_top and ntci_conversion_checker
`timescale 1ns / 1ps

module tb_ntc_table_interpolator_top;
    import ntci_pkg::*;

    localparam int TABLE_DEPTH    = NTCI_TABLE_DEPTH;
    localparam int RES_MAX        = (1 << RES_W) - 1;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PCT       = 23;
    localparam int SETTLE_CYCLES  = 160;   // outlasts the longest conversion
    localparam int TAIL_CYCLES    = 200;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;  // cycles with no beat on either channel
    localparam int RANDOM_BEATS   = 800;
    localparam int PHASE_BEATS    = 100;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_cmd;
    logic [IDX_W-1:0]         s_entry_index;
    logic [RES_W-1:0]         s_resistance_ohms;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [TEMP_W-1:0] m_temperature_q8;
    logic [1:0]               m_clamp_status;

    int outstanding;
    int mismatches;

    // stimulus-side copy of what was loaded, used only to aim conversions
    logic [RES_W-1:0] written_ohms [TABLE_DEPTH];
    int active_entries = ENTRIES_USED_RST;
    int beats_sent = 0;
    logic sender_calm = 1'b0;
    logic receiver_calm;
    int holdoff_ask;
    int quiet_cycles = 0;

    always #1 aclk = ~aclk;

    ntc_table_interpolator_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_entry_index     (s_entry_index),
        .s_resistance_ohms (s_resistance_ohms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temperature_q8  (m_temperature_q8),
        .m_clamp_status    (m_clamp_status)
    );

    ntci_conversion_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) conv_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_entry_index     (s_entry_index),
        .s_resistance_ohms (s_resistance_ohms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temperature_q8  (m_temperature_q8),
        .m_clamp_status    (m_clamp_status),
        .outstanding       (outstanding),
        .mismatches        (mismatches)
    );

    // watchdog: any beat on either channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, a calm window, and one long hold-off
    // that the main process asks for by bumping holdoff_ask
    initial begin
        int holdoff_seen;
        int hold;
        holdoff_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_seen != holdoff_ask) begin
                holdoff_seen = holdoff_ask;
                m_ready <= 1'b0;
                for (hold = 0; hold < HOLDOFF_CYCLES; hold++) @(posedge aclk);
            end else if (receiver_calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // one input beat: optional idle gap, then hold valid until accepted;
    // handshake sampled at the falling edge so the rising edge after is the accept
    task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [RES_W-1:0] ohms);
        if (!sender_calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_entry_index <= idx;
        s_resistance_ohms <= ohms;
        if (cmd == CMD_LOAD) written_ohms[idx] = ohms;
        beats_sent++;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // entry index is a don't-care on conversions, so randomize it
    task automatic convert(input logic [RES_W-1:0] ohms);
        send_beat(CMD_CONVERT, IDX_W'($urandom_range(TABLE_DEPTH - 1)), ohms);
    endtask

    // stop sending and wait for every pending temperature to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // registers change only while idle; loads leave no result behind,
    // so give the block a full conversion time after the drain
    task automatic set_config(input int entries, input int base);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ENTRIES_USED;
        cfg_wdata <= CFG_DATA_W'(entries);
        @(posedge aclk);
        cfg_index <= REG_BASE_TEMP;
        cfg_wdata <= CFG_DATA_W'(base);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_entries = (entries < 2) ? 2 : (entries > TABLE_DEPTH) ? TABLE_DEPTH : entries;
    endtask

    // falling table, every entry written, start high enough to stay non-negative
    task automatic fill_table(input int step_lo, input int step_hi);
        int unsigned level;
        int k;
        level = $urandom_range(RES_MAX, (TABLE_DEPTH - 1) * step_hi);
        for (k = 0; k < TABLE_DEPTH; k++) begin
            send_beat(CMD_LOAD, IDX_W'(k), RES_W'(level));
            level -= $urandom_range(step_hi, step_lo);
        end
    endtask

    // mostly inside a bracketing interval, some past either end, some anywhere
    function automatic logic [RES_W-1:0] pick_resistance();
        int sel;
        int i;
        logic [RES_W-1:0] hi, lo, r;
        sel = $urandom_range(99);
        if (sel < 60) begin
            i = $urandom_range(active_entries - 2);
            hi = written_ohms[i];
            lo = written_ohms[i+1];
            if (hi <= lo) begin
                r = hi;
            end else begin
                case ($urandom_range(3))
                    0: r = hi;
                    1: r = lo + 1'b1;
                    default: r = RES_W'($urandom_range(hi, lo + 1));
                endcase
            end
        end else if (sel < 75) begin
            r = RES_W'($urandom_range(RES_MAX, written_ohms[0]));
        end else if (sel < 90) begin
            r = RES_W'($urandom_range(written_ohms[active_entries-1], 0));
        end else begin
            r = RES_W'($urandom());
        end
        return r;
    endfunction

    initial begin
        int phase;
        int random_start;
        int entries;
        int k;
        logic [RES_W-1:0] lo_nb, hi_nb;

        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_ENTRIES_USED;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_cmd <= CMD_LOAD;
        s_entry_index <= '0;
        s_resistance_ohms <= '0;
        receiver_calm <= 1'b0;
        holdoff_ask <= 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config (111 entries from -10 C); all entries loaded before any
        // conversion so no scan ever reads an unwritten entry. entry_index is
        // 7 bits, so an out-of-range load index cannot be produced here
        fill_table(1000, 90000);
        convert('0);
        convert(RES_W'(RES_MAX));
        convert(written_ohms[0]);
        convert(written_ohms[0] - 1'b1);
        convert(written_ohms[110]);
        convert(written_ohms[110] + 1'b1);
        convert(written_ohms[5]);
        convert(written_ohms[6] + 1'b1);
        convert(written_ohms[6] + (written_ohms[5] - written_ohms[6]) / 2);

        // entry count below two acts as two, coldest base
        set_config(0, -64);
        convert(written_ohms[1]);
        convert(written_ohms[1] + 1'b1);
        convert(written_ohms[0] - 1'b1);

        set_config(1, 63);
        convert(written_ohms[1] + 1'b1);
        convert(written_ohms[1]);

        // entry count above depth acts as depth, hottest end of the range
        set_config(255, 63);
        convert(written_ohms[TABLE_DEPTH-1]);
        convert(written_ohms[TABLE_DEPTH-1] + 1'b1);
        convert(written_ohms[0]);

        set_config(129, 0);
        convert(written_ohms[64] - 3'd7);
        set_config(128, -1);
        convert(written_ohms[100] + 2'd3);

        // random phases, each with its own register settings
        phase = 0;
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            case ($urandom_range(4))
                0: entries = $urandom_range(3);
                1: entries = $urandom_range(255, TABLE_DEPTH + 1);
                2: entries = TABLE_DEPTH;
                default: entries = $urandom_range(TABLE_DEPTH - 1, 2);
            endcase
            set_config(entries, int'($urandom_range(127)) - 64);

            // small steps give tiny divisors and flat spots, large ones use the top bits
            if (phase % 3 == 0) begin
                if ($urandom_range(1)) fill_table(0, 3);
                else fill_table(1000, 90000);
            end

            // phase 1: long result stall while beats keep coming, block backs up
            if (phase == 1) holdoff_ask <= holdoff_ask + 1;
            // phase 2: no idling on either side
            if (phase == 2) begin
                receiver_calm <= 1'b1;
                sender_calm = 1'b1;
            end

            repeat (PHASE_BEATS) begin
                if ($urandom_range(99) < 12) begin
                    // rewrite one entry, mostly keeping the table falling
                    k = $urandom_range(TABLE_DEPTH - 1);
                    lo_nb = (k < TABLE_DEPTH - 1) ? written_ohms[k+1] : '0;
                    hi_nb = (k > 0) ? written_ohms[k-1] : RES_W'(RES_MAX);
                    if ($urandom_range(99) < 20)
                        send_beat(CMD_LOAD, IDX_W'(k), RES_W'($urandom()));
                    else
                        send_beat(CMD_LOAD, IDX_W'(k), RES_W'($urandom_range(hi_nb, lo_nb)));
                end else begin
                    convert(pick_resistance());
                end
            end

            if (phase == 2) begin
                receiver_calm <= 1'b0;
                sender_calm = 1'b0;
            end
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
